[src/keypad_time_date_entry_unit_defines.svh]
// assertion macros shared by the keypad time and date entry block
`ifndef KEYPAD_TIME_DATE_ENTRY_UNIT_DEFINES_SVH
`define KEYPAD_TIME_DATE_ENTRY_UNIT_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define KTE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define KTE_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/kte_pkg.sv]
// types, codes and helper functions of the keypad time and date entry block
package kte_pkg;

  localparam int NumDigits = 15;
  localparam logic [3:0] LastPos = 4'd14;

  // item kinds
  localparam logic [2:0] MODE_DIGIT  = 3'd0;
  localparam logic [2:0] MODE_FWD    = 3'd1;
  localparam logic [2:0] MODE_BACK   = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_COMMIT = 3'd4;
  localparam logic [2:0] MODE_LOAD   = 3'd5;

  // result event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_OK     = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

  // range limits checked at commit (MaxDigit is checked at digit entry)
  localparam logic [7:0]  MaxHour   = 8'd23;
  localparam logic [7:0]  MaxMinSec = 8'd59;
  localparam logic [7:0]  MaxDay    = 8'd31;
  localparam logic [7:0]  MaxMonth  = 8'd12;
  localparam logic [3:0]  MaxWday   = 4'd6;
  localparam logic [3:0]  MaxDigit  = 4'd9;
  localparam logic [14:0] MinYear   = 15'd2000;
  localparam logic [14:0] MaxYear   = 15'd2099;

  typedef logic [3:0] digit_t;
  typedef logic [NumDigits-1:0][3:0] digit_vec_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
  } cur_t;

  typedef struct packed {
    logic [2:0] mode;
    digit_t     digit;
    cur_t       cur;
  } op_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day_of_month;
    logic [3:0]  month_num;
    logic [11:0] year_num;
    logic [2:0]  weekday;
  } result_t;

  typedef struct packed {
    digit_t      q;
    logic [11:0] rem;
  } split_t;

  // one decimal digit off the top: parallel compares against unit multiples
  function automatic split_t dec_split(input logic [11:0] v, input logic [13:0] unit);
    split_t      r;
    logic [13:0] sub;
    r.q = '0;
    sub = '0;
    for (int i = 1; i < 10; i++) begin
      if ({2'b00, v} >= unit * 14'(i)) begin
        r.q = 4'(i);
        sub = unit * 14'(i);
      end
    end
    r.rem = v - sub[11:0];
    return r;
  endfunction

endpackage

[src/kte_load.sv]
// splits the current clock values into the fifteen edit digits
module kte_load
  import kte_pkg::*;
(
  input  cur_t       cur_i,
  output digit_vec_t digits_o
);

  split_t hr_s, mi_s, se_s, dy_s, mo_s, y1_s, y2_s, y3_s;

  always_comb begin
    hr_s = dec_split({7'b0, cur_i.hour}, 14'd10);
    mi_s = dec_split({6'b0, cur_i.minute}, 14'd10);
    se_s = dec_split({6'b0, cur_i.second}, 14'd10);
    dy_s = dec_split({7'b0, cur_i.day}, 14'd10);
    mo_s = dec_split({8'b0, cur_i.month}, 14'd10);
    // year peeled one decimal place per step
    y1_s = dec_split(cur_i.year, 14'd1000);
    y2_s = dec_split(y1_s.rem, 14'd100);
    y3_s = dec_split(y2_s.rem, 14'd10);

    digits_o[0]  = hr_s.q;
    digits_o[1]  = hr_s.rem[3:0];
    digits_o[2]  = mi_s.q;
    digits_o[3]  = mi_s.rem[3:0];
    digits_o[4]  = se_s.q;
    digits_o[5]  = se_s.rem[3:0];
    digits_o[6]  = dy_s.q;
    digits_o[7]  = dy_s.rem[3:0];
    digits_o[8]  = mo_s.q;
    digits_o[9]  = mo_s.rem[3:0];
    digits_o[10] = y1_s.q;
    digits_o[11] = y2_s.q;
    digits_o[12] = y3_s.q;
    digits_o[13] = y3_s.rem[3:0];
    digits_o[14] = {1'b0, cur_i.weekday};
  end

endmodule

[src/kte_commit.sv]
// joins the digits into values and range-checks them on commit
module kte_commit
  import kte_pkg::*;
(
  input  logic [2:0] mode_i,
  input  digit_vec_t digits_i,
  output result_t    res_o
);

  logic [7:0]  hh, mm, ss, dd, mo;
  logic [14:0] yy;
  logic        bad;

  always_comb begin
    hh = 8'(digits_i[0]) * 8'd10 + 8'(digits_i[1]);
    mm = 8'(digits_i[2]) * 8'd10 + 8'(digits_i[3]);
    ss = 8'(digits_i[4]) * 8'd10 + 8'(digits_i[5]);
    dd = 8'(digits_i[6]) * 8'd10 + 8'(digits_i[7]);
    mo = 8'(digits_i[8]) * 8'd10 + 8'(digits_i[9]);
    yy = 15'(digits_i[10]) * 15'd1000 + 15'(digits_i[11]) * 15'd100
       + 15'(digits_i[12]) * 15'd10 + 15'(digits_i[13]);
    bad = (hh > MaxHour) || (mm > MaxMinSec) || (ss > MaxMinSec)
       || (dd == 8'd0) || (dd > MaxDay) || (mo == 8'd0) || (mo > MaxMonth)
       || (digits_i[14] > MaxWday) || (yy < MinYear) || (yy > MaxYear);

    res_o = '0;
    if (mode_i == MODE_COMMIT) begin
      if (bad) begin
        res_o.event_res = EV_REJECT;
      end else begin
        res_o.event_res    = EV_OK;
        res_o.hour         = hh[4:0];
        res_o.minute       = mm[5:0];
        res_o.second       = ss[5:0];
        res_o.day_of_month = dd[4:0];
        res_o.month_num    = mo[3:0];
        res_o.year_num     = yy[11:0];
        res_o.weekday      = digits_i[14][2:0];
      end
    end
  end

endmodule

[src/kte_edit.sv]
// digit store and cursor with their per-item update
module kte_edit
  import kte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  op_t        op_i,
  output digit_vec_t digits_o,
  output logic [3:0] cursor_next_o
);

  digit_vec_t digits_q, digits_d, load_digits;
  logic [3:0] cursor_q, cursor_d;

  kte_load u_load (
    .cur_i    (op_i.cur),
    .digits_o (load_digits)
  );

  always_comb begin
    digits_d = digits_q;
    cursor_d = cursor_q;
    if (fire_i) begin
      unique case (op_i.mode)
        MODE_DIGIT: begin
          if (op_i.digit <= MaxDigit && cursor_q <= LastPos) begin
            digits_d[cursor_q] = op_i.digit;
          end
        end
        MODE_FWD: begin
          if (cursor_q < LastPos) cursor_d = cursor_q + 4'd1;
        end
        MODE_BACK: begin
          if (cursor_q != 4'd0) cursor_d = cursor_q - 4'd1;
        end
        MODE_CLEAR: begin
          digits_d = '0;
          cursor_d = '0;
        end
        MODE_LOAD: begin
          digits_d = load_digits;
          cursor_d = '0;
        end
        // commit and unused codes leave the state alone
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      cursor_q <= '0;
    end else begin
      digits_q <= digits_d;
      cursor_q <= cursor_d;
    end
  end

  assign digits_o      = digits_q;
  assign cursor_next_o = cursor_d;

endmodule

[src/keypad_time_date_entry_unit.sv]
// Keypad time and date entry editor, top level.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one key item: mode, digit
//   and the current clock values used by a load. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per item: the
//   cursor after the item, an event code and, for an accepted commit, the
//   committed time and date fields (zero otherwise).
//   An item is taken into an input register, processed in one pass of small
//   logic against the digit store and cursor, and lands in the result
//   register. Throughput is one item per cycle while the receiver does not
//   stall; the digit store and cursor update in the same cycle as the item
//   is processed, so consecutive items chain.
//   While the receiver stalls, the result register holds and the input
//   register holds its item; a new item is still taken while the input
//   register is empty, and in_stall_o rises only when both are full.
//   Reset clears all fifteen digits, homes the cursor and empties both
//   registers.
`include "keypad_time_date_entry_unit_defines.svh"

module keypad_time_date_entry_unit
  import kte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  digit_i,
  input  logic [4:0]  cur_hour_i,
  input  logic [5:0]  cur_minute_i,
  input  logic [5:0]  cur_second_i,
  input  logic [4:0]  cur_day_i,
  input  logic [3:0]  cur_month_i,
  input  logic [11:0] cur_year_i,
  input  logic [2:0]  cur_weekday_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  cursor_o,
  output logic [1:0]  event_res_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_num_o,
  output logic [11:0] year_num_o,
  output logic [2:0]  weekday_o
);

  logic       s1_valid_q;
  op_t        s1_op_q;
  logic       out_free, s1_en, fire;
  digit_vec_t digits;
  logic [3:0] cursor_next;
  result_t    res;
  logic       out_valid_q;
  logic [3:0] cursor_q;
  result_t    res_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign s1_en      = !s1_valid_q || out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_op_q <= '{mode: mode_i, digit: digit_i,
                   cur: '{hour: cur_hour_i, minute: cur_minute_i,
                          second: cur_second_i, day: cur_day_i,
                          month: cur_month_i, year: cur_year_i,
                          weekday: cur_weekday_i}};
    end
  end

  kte_edit u_edit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .op_i          (s1_op_q),
    .digits_o      (digits),
    .cursor_next_o (cursor_next)
  );

  // commit checks the digits as they stood before this item
  kte_commit u_commit (
    .mode_i   (s1_op_q.mode),
    .digits_i (digits),
    .res_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cursor_q <= cursor_next;
      res_q    <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_o       = cursor_q;
  assign event_res_o    = res_q.event_res;
  assign hour_o         = res_q.hour;
  assign minute_o       = res_q.minute;
  assign second_o       = res_q.second;
  assign day_of_month_o = res_q.day_of_month;
  assign month_num_o    = res_q.month_num;
  assign year_num_o     = res_q.year_num;
  assign weekday_o      = res_q.weekday;

  `KTE_NEVER(a_cursor_range, clk_i, rst_ni,
    out_valid_o && (cursor_o > LastPos), "cursor past last digit")
  `KTE_ASSERT(a_ok_fields, clk_i, rst_ni,
    (out_valid_o && (event_res_o == EV_OK)) |-> ((hour_o <= 5'd23) && (month_num_o != 4'd0)
      && (year_num_o >= 12'd2000) && (year_num_o <= 12'd2099)),
    "accepted commit out of range")
  `KTE_ASSERT(a_zero_fields, clk_i, rst_ni,
    (out_valid_o && (event_res_o != EV_OK)) |-> ((hour_o == 5'd0) && (year_num_o == 12'd0)
      && (weekday_o == 3'd0)),
    "fields nonzero without accepted commit")
  `KTE_NEVER(a_event_code, clk_i, rst_ni,
    out_valid_o && (event_res_o == 2'd3), "undefined event code")
  `KTE_ASSERT(a_stall_full, clk_i, rst_ni,
    in_stall_o |-> (s1_valid_q && out_valid_q), "input stalled with free space")

endmodule

[bench/testbench.sv]
// self-checking testbench of the keypad time and date entry editor
module testbench;
  import kte_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int CycleLimit = 200000;
  localparam int KeyCount = 850;

  typedef struct packed {
    logic [3:0] cursor;
    result_t    res;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [3:0]  digit_i = '0;
  logic [4:0]  cur_hour_i = '0;
  logic [5:0]  cur_minute_i = '0;
  logic [5:0]  cur_second_i = '0;
  logic [4:0]  cur_day_i = '0;
  logic [3:0]  cur_month_i = '0;
  logic [11:0] cur_year_i = '0;
  logic [2:0]  cur_weekday_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  cursor_o;
  logic [1:0]  event_res_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_num_o;
  logic [11:0] year_num_o;
  logic [2:0]  weekday_o;

  op_t      key_queue[$];
  outcome_t pending_outcomes[$];
  op_t      key_on_bus = '0;
  bit       key_taken = 1'b0;
  bit       broken = 1'b0;
  int       cycle_count = 0;

  // predictor state: the digit store and the cursor
  logic [3:0] key_digits [NumDigits];
  logic [3:0] cursor_model = '0;

  keypad_time_date_entry_unit DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void put_pair(input int at, input int unsigned v);
    key_digits[at]   = 4'((v / 10) % 10);
    key_digits[at+1] = 4'(v % 10);
  endfunction

  function automatic int unsigned pair_value(input int at);
    return 10 * int'(key_digits[at]) + int'(key_digits[at+1]);
  endfunction

  // applies one key to the digit store and cursor, returns the result it causes
  function automatic outcome_t edit_key(input op_t k);
    outcome_t    o;
    int unsigned hh, mm, ss, dd, mo, yy, wd;
    o = '0;
    case (k.mode)
      MODE_DIGIT: begin
        if (k.digit <= MaxDigit) key_digits[cursor_model] = k.digit;
      end
      MODE_FWD: begin
        if (cursor_model < LastPos) cursor_model = cursor_model + 4'd1;
      end
      MODE_BACK: begin
        if (cursor_model != 4'd0) cursor_model = cursor_model - 4'd1;
      end
      MODE_CLEAR: begin
        foreach (key_digits[i]) key_digits[i] = '0;
        cursor_model = '0;
      end
      MODE_COMMIT: begin
        hh = pair_value(0);
        mm = pair_value(2);
        ss = pair_value(4);
        dd = pair_value(6);
        mo = pair_value(8);
        yy = 1000 * int'(key_digits[10]) + 100 * int'(key_digits[11])
           + 10 * int'(key_digits[12]) + int'(key_digits[13]);
        wd = key_digits[14];
        if (hh > MaxHour || mm > MaxMinSec || ss > MaxMinSec || dd < 1 || dd > MaxDay ||
            mo < 1 || mo > MaxMonth || wd > MaxWday || yy < MinYear || yy > MaxYear) begin
          o.res.event_res = EV_REJECT;
        end else begin
          o.res.event_res    = EV_OK;
          o.res.hour         = 5'(hh);
          o.res.minute       = 6'(mm);
          o.res.second       = 6'(ss);
          o.res.day_of_month = 5'(dd);
          o.res.month_num    = 4'(mo);
          o.res.year_num     = 12'(yy);
          o.res.weekday      = 3'(wd);
        end
      end
      MODE_LOAD: begin
        put_pair(0, k.cur.hour);
        put_pair(2, k.cur.minute);
        put_pair(4, k.cur.second);
        put_pair(6, k.cur.day);
        put_pair(8, k.cur.month);
        key_digits[10] = 4'((k.cur.year / 1000) % 10);
        key_digits[11] = 4'((k.cur.year / 100) % 10);
        key_digits[12] = 4'((k.cur.year / 10) % 10);
        key_digits[13] = 4'(k.cur.year % 10);
        key_digits[14] = {1'b0, k.cur.weekday};
        cursor_model = '0;
      end
      default: ;
    endcase
    o.cursor = cursor_model;
    return o;
  endfunction

  // clock fields of non-load keys are random, they must not matter
  function automatic void queue_key(input logic [2:0] m, input logic [3:0] d);
    op_t k;
    k = '0;
    k.mode = m;
    k.digit = d;
    k.cur.hour = 5'($urandom);
    k.cur.minute = 6'($urandom);
    k.cur.second = 6'($urandom);
    k.cur.day = 5'($urandom);
    k.cur.month = 4'($urandom);
    k.cur.year = 12'($urandom);
    k.cur.weekday = 3'($urandom);
    key_queue.push_back(k);
  endfunction

  function automatic void queue_load(input int unsigned h, mi, s, dy, mo, yr, wd);
    op_t k;
    k = '0;
    k.mode = MODE_LOAD;
    k.digit = 4'($urandom);
    k.cur.hour = 5'(h);
    k.cur.minute = 6'(mi);
    k.cur.second = 6'(s);
    k.cur.day = 5'(dy);
    k.cur.month = 4'(mo);
    k.cur.year = 12'(yr);
    k.cur.weekday = 3'(wd);
    key_queue.push_back(k);
  endfunction

  // picks a value in range, now and then a value up to 99 that may be out of range
  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(99) < 10) return $urandom_range(99);
    return $urandom_range(hi, lo);
  endfunction

  // a setting session: clear and type all digits, or load and touch up, then commit
  function automatic void queue_session();
    int unsigned h, mi, s, dy, mo, yr, wd;
    int unsigned tgt [NumDigits];
    h  = pick(0, 23);
    mi = pick(0, 59);
    s  = pick(0, 59);
    dy = pick(1, 31);
    mo = pick(1, 12);
    yr = ($urandom_range(99) < 12) ? $urandom_range(9999) : 2000 + $urandom_range(99);
    wd = ($urandom_range(99) < 10) ? $urandom_range(9) : $urandom_range(6);
    if ($urandom_range(1) == 0) begin
      tgt = '{h / 10, h % 10, mi / 10, mi % 10, s / 10, s % 10, dy / 10, dy % 10,
              mo / 10, mo % 10, (yr / 1000) % 10, (yr / 100) % 10, (yr / 10) % 10,
              yr % 10, wd};
      queue_key(MODE_CLEAR, 4'($urandom));
      for (int i = 0; i < NumDigits; i++) begin
        if ($urandom_range(99) < 6) queue_key(MODE_DIGIT, 4'($urandom_range(15)));
        queue_key(MODE_DIGIT, 4'(tgt[i]));
        if ($urandom_range(99) < 8) begin
          queue_key(MODE_BACK, 4'($urandom));
          queue_key(MODE_FWD, 4'($urandom));
        end
        if (i < NumDigits - 1) queue_key(MODE_FWD, 4'($urandom));
      end
      // pushes against the last position
      repeat ($urandom_range(2)) queue_key(MODE_FWD, 4'($urandom));
    end else begin
      if ($urandom_range(99) < 15)
        queue_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        queue_load(h, mi, s, dy, mo, yr % 4096, wd % 8);
      repeat ($urandom_range(3)) begin
        repeat ($urandom_range(5)) queue_key(MODE_FWD, 4'($urandom));
        if ($urandom_range(3) == 0) queue_key(MODE_BACK, 4'($urandom));
        queue_key(MODE_DIGIT, 4'($urandom_range(9)));
      end
    end
    queue_key(MODE_COMMIT, 4'($urandom));
  endfunction

  // driver: a new item goes out once the current one has been transferred
  always @(negedge clk_i) begin
    op_t k;
    bit  calm;
    calm = cycle_count >= 300 && cycle_count < 500;
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 18);
    if (rst_ni && (!in_valid_i || key_taken)) begin
      if (key_queue.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
        k = key_queue.pop_front();
        key_on_bus = k;
        mode_i <= k.mode;
        digit_i <= k.digit;
        cur_hour_i <= k.cur.hour;
        cur_minute_i <= k.cur.minute;
        cur_second_i <= k.cur.second;
        cur_day_i <= k.cur.day;
        cur_month_i <= k.cur.month;
        cur_year_i <= k.cur.year;
        cur_weekday_i <= k.cur.weekday;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    key_taken = 1'b0;
  end

  function automatic void check_field(input string what, input int unsigned want, got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      broken = 1'b1;
    end
  endfunction

  // monitor: results are checked before this edge's input transfer is predicted
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with none expected, cursor %0d event %0d",
                 $time, cursor_o, event_res_o);
        broken = 1'b1;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("cursor", want.cursor, cursor_o);
        check_field("event_res", want.res.event_res, event_res_o);
        check_field("hour", want.res.hour, hour_o);
        check_field("minute", want.res.minute, minute_o);
        check_field("second", want.res.second, second_o);
        check_field("day_of_month", want.res.day_of_month, day_of_month_o);
        check_field("month_num", want.res.month_num, month_num_o);
        check_field("year_num", want.res.year_num, year_num_o);
        check_field("weekday", want.res.weekday, weekday_o);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_outcomes.push_back(edit_key(key_on_bus));
      key_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (key_digits[i]) key_digits[i] = '0;
    // directed: fresh state, ignored keys, cursor at the low end, load extremes
    queue_key(MODE_COMMIT, 4'd0);
    queue_key(MODE_BACK, 4'd0);
    queue_key(MODE_DIGIT, 4'd15);
    queue_key(MODE_DIGIT, 4'd10);
    queue_key(MODE_SPARE6, 4'd3);
    queue_key(MODE_SPARE7, 4'd15);
    queue_key(MODE_DIGIT, 4'd9);
    queue_key(MODE_FWD, 4'd0);
    queue_key(MODE_DIGIT, 4'd0);
    queue_key(MODE_BACK, 4'd0);
    queue_key(MODE_COMMIT, 4'd0);
    queue_load(12, 34, 56, 31, 12, 2099, 6);
    queue_key(MODE_COMMIT, 4'd0);
    queue_load(0, 0, 0, 1, 1, 2000, 0);
    queue_key(MODE_COMMIT, 4'd0);
    queue_load(23, 59, 59, 31, 12, 1999, 6);
    queue_key(MODE_COMMIT, 4'd0);
    queue_load(31, 63, 63, 31, 15, 4095, 7);
    queue_key(MODE_COMMIT, 4'd0);
    queue_load(23, 59, 59, 0, 12, 2050, 3);
    queue_key(MODE_COMMIT, 4'd0);
    queue_key(MODE_CLEAR, 4'd0);
    queue_key(MODE_COMMIT, 4'd0);
    while (key_queue.size() < KeyCount) begin
      if ($urandom_range(99) < 75) begin
        queue_session();
      end else begin
        repeat ($urandom_range(5, 1)) queue_key(3'($urandom_range(7)), 4'($urandom_range(15)));
      end
    end

    repeat (3) @(posedge clk_i);
    #3 rst_ni = 1'b1;
    while (key_queue.size() != 0 || in_valid_i || pending_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (!broken && pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
